// ----- design/rvx_pkg.sv -----
package rvx_pkg;

	localparam int MEM_BYTES_DEF = 65536;

	localparam logic [6:0] OPC_OP     = 7'h33;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_JAL    = 7'h6F;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;
	localparam logic [6:0] F7_MULDIV = 7'h01;

	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SRL  = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_MUL    = 3'd0;
	localparam logic [2:0] F3_MULH   = 3'd1;
	localparam logic [2:0] F3_MULHSU = 3'd2;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_LB = 3'd0;
	localparam logic [2:0] F3_LH = 3'd1;
	localparam logic [2:0] F3_LW = 3'd2;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [31:0] ECALL_WORD = 32'h0000_0073;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ILL   = 3'd1;
	localparam logic [2:0] ST_RANGE = 3'd2;
	localparam logic [2:0] ST_HALT  = 3'd3;
	localparam logic [2:0] ST_ENV   = 3'd4;

	typedef enum logic [2:0] {
		KIND_ALU,
		KIND_MUL,
		KIND_DIV,
		KIND_LOAD,
		KIND_STORE
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_MEM,
		S_DIV,
		S_WB
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic div_start;
		logic mem_step;
		logic clr_step;
		logic wb;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  mem_done;
		logic  div_done;
		logic  clr_done;
	} sts_t;

endpackage

// ----- design/rvx_in_if.sv -----
interface rvx_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction_word;

	modport source (output valid, output instruction_word, input ready);
	modport sink (input valid, input instruction_word, output ready);
endinterface

// ----- design/rvx_out_if.sv -----
interface rvx_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_pc;
	logic [2:0]  status_code;
	logic        reg_written;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic        branch_taken;

	modport source (output valid, output next_pc, output status_code, output reg_written,
		output dest_index, output dest_value, output branch_taken, input ready);
	modport sink (input valid, input next_pc, input status_code, input reg_written,
		input dest_index, input dest_value, input branch_taken, output ready);
endinterface

// ----- design/rv32im_instruction_executor.sv -----
// RV32IM executor: one instruction word per transfer on instr, one result per
// instruction on result. After reset a clearing pass writes zero to every data
// memory byte, one byte a cycle, before the first word is taken. Each
// instruction passes accept with register read, execute and writeback;
// multiplies take the same path, loads and stores add memory steps for the
// byte-wide memory port, and divide/remainder wait in a divide state for the
// radix-2 divider. A new word can be taken from the cycle after writeback,
// while the previous result may still wait in the output register.
module rv32im_instruction_executor #(
	parameter int MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rvx_in_if.sink     instr,
	rvx_out_if.source  result
);

	rvx_pkg::cmd_t cmd;
	rvx_pkg::sts_t sts;

	rvx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (instr.valid),
		.in_ready  (instr.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvx_dpath #(.MEM_BYTES(MEM_BYTES)) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_word      (instr.instruction_word),
		.cmd          (cmd),
		.sts          (sts),
		.next_pc      (result.next_pc),
		.status_code  (result.status_code),
		.reg_written  (result.reg_written),
		.dest_index   (result.dest_index),
		.dest_value   (result.dest_value),
		.branch_taken (result.branch_taken)
	);

endmodule

// ----- design/rvx_div.sv -----
module rvx_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	input  logic        sgn,
	input  logic        rem,
	output logic        done,
	output logic [31:0] res
);

	logic        busy_q, done_q, qneg_q, rneg_q, rem_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q, dv_q, r_q;
	logic [31:0] ma, mb;
	logic [32:0] rs;
	logic        fits;

	assign ma = (sgn && dividend[31]) ? (32'd0 - dividend) : dividend;
	assign mb = (sgn && divisor[31]) ? (32'd0 - divisor) : divisor;
	assign rs = {r_q, quo_q[31]};
	assign fits = rs >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= ma;
			dv_q <= mb;
			r_q <= '0;
			// a zero divisor leaves the all-ones quotient unsigned
			qneg_q <= sgn && (dividend[31] ^ divisor[31]) && (divisor != 32'd0);
			rneg_q <= sgn && dividend[31];
			rem_q <= rem;
		end else if (busy_q) begin
			if (fits) begin
				r_q <= 32'(rs - {1'b0, dv_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				r_q <= rs[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign res = rem_q ? (rneg_q ? (32'd0 - r_q) : r_q)
		: (qneg_q ? (32'd0 - quo_q) : quo_q);

endmodule

// ----- design/rvx_dpath.sv -----
module rvx_dpath #(
	parameter int MEM_BYTES = rvx_pkg::MEM_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   in_word,
	input  rvx_pkg::cmd_t cmd,
	output rvx_pkg::sts_t sts,
	output logic [31:0]   next_pc,
	output logic [2:0]    status_code,
	output logic          reg_written,
	output logic [4:0]    dest_index,
	output logic [31:0]   dest_value,
	output logic          branch_taken
);

	localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

	function automatic logic [31:0] alu(input logic [2:0] f, input logic alt,
		input logic [31:0] x, input logic [31:0] y);
		logic [4:0] sh;
		sh = y[4:0];
		case (f)
			rvx_pkg::F3_ADD:  alu = alt ? (x - y) : (x + y);
			rvx_pkg::F3_SLL:  alu = x << sh;
			rvx_pkg::F3_SLT:  alu = {31'd0, $signed(x) < $signed(y)};
			rvx_pkg::F3_SLTU: alu = {31'd0, x < y};
			rvx_pkg::F3_XOR:  alu = x ^ y;
			rvx_pkg::F3_SRL:  alu = alt ? 32'($signed(x) >>> sh) : (x >> sh);
			rvx_pkg::F3_OR:   alu = x | y;
			default:          alu = x & y;
		endcase
	endfunction

	logic [31:0] rf [32];
	logic [31:0] rf_vld_q;
	logic [31:0] ra_q, rb_q;
	logic        va_q, vb_q;
	logic [31:0] ir_q, pc_q;
	logic        halt_q;
	logic [31:0] a_op, b_op;

	logic [7:0]    mem [MEM_BYTES];
	logic [AW-1:0] clr_q, maddr;
	logic [7:0]    mrd_q, mwd;
	logic          mwe;

	logic [2:0]          st_q;
	logic                wr_q, tk_q;
	logic [31:0]         val_q, nxt_q, ea_q, ld_q;
	rvx_pkg::kind_t      kind_q;
	logic [2:0]          msize_q, mcnt_q;
	logic [63:0]         prod_s1;

	logic [6:0]  opc, f7;
	logic [4:0]  rd, rs1, rs2;
	logic [2:0]  f3;
	logic [31:0] immi, imms, immb, immj, immu;

	logic [2:0]     st;
	logic           ok, wr, tk, inr, cnd;
	logic [31:0]    val, nxt, ea;
	logic [2:0]     msize;
	rvx_pkg::kind_t kind;

	logic        mas, mbs;
	logic signed [65:0] prod;
	logic        div_done;
	logic [31:0] div_res, fval;
	logic        wr_ok;

	assign a_op = va_q ? ra_q : 32'd0;
	assign b_op = vb_q ? rb_q : 32'd0;

	assign opc = ir_q[6:0];
	assign rd  = ir_q[11:7];
	assign f3  = ir_q[14:12];
	assign rs1 = ir_q[19:15];
	assign rs2 = ir_q[24:20];
	assign f7  = ir_q[31:25];
	assign immi = {{20{ir_q[31]}}, ir_q[31:20]};
	assign imms = {{20{ir_q[31]}}, ir_q[31:25], ir_q[11:7]};
	assign immb = {{19{ir_q[31]}}, ir_q[31], ir_q[7], ir_q[30:25], ir_q[11:8], 1'b0};
	assign immj = {{11{ir_q[31]}}, ir_q[31], ir_q[19:12], ir_q[20], ir_q[30:21], 1'b0};
	assign immu = {ir_q[31:12], 12'd0};

	always_comb begin
		ok = 1'b1;
		st = rvx_pkg::ST_OK;
		wr = 1'b0;
		tk = 1'b0;
		val = '0;
		nxt = pc_q + 32'd4;
		kind = rvx_pkg::KIND_ALU;
		ea = a_op + immi;
		msize = 3'd0;
		cnd = 1'b0;
		case (opc)
			rvx_pkg::OPC_OP: begin
				if (f7 == rvx_pkg::F7_MULDIV) begin
					kind = f3[2] ? rvx_pkg::KIND_DIV : rvx_pkg::KIND_MUL;
					wr = 1'b1;
				end else if (f7 == rvx_pkg::F7_BASE) begin
					val = alu(f3, 1'b0, a_op, b_op);
					wr = 1'b1;
				end else if (f7 == rvx_pkg::F7_ALT &&
					(f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SRL)) begin
					val = alu(f3, 1'b1, a_op, b_op);
					wr = 1'b1;
				end else begin
					ok = 1'b0;
				end
			end
			rvx_pkg::OPC_IMM: begin
				if (f3 == rvx_pkg::F3_SLL || f3 == rvx_pkg::F3_SRL) begin
					if (f7 == rvx_pkg::F7_BASE ||
						(f3 == rvx_pkg::F3_SRL && f7 == rvx_pkg::F7_ALT)) begin
						val = alu(f3, f7[5], a_op, {27'd0, rs2});
						wr = 1'b1;
					end else begin
						ok = 1'b0;
					end
				end else begin
					val = alu(f3, 1'b0, a_op, immi);
					wr = 1'b1;
				end
			end
			rvx_pkg::OPC_LUI: begin
				val = immu;
				wr = 1'b1;
			end
			rvx_pkg::OPC_AUIPC: begin
				val = pc_q + immu;
				wr = 1'b1;
			end
			rvx_pkg::OPC_JAL: begin
				val = pc_q + 32'd4;
				wr = 1'b1;
				nxt = pc_q + immj;
				tk = 1'b1;
			end
			rvx_pkg::OPC_JALR: begin
				if (f3 != 3'd0) begin
					ok = 1'b0;
				end else if (rs1 == 5'd1 && rd == 5'd0 && ir_q[31:20] == 12'd0 &&
					a_op == 32'd0) begin
					st = rvx_pkg::ST_HALT;
				end else begin
					val = pc_q + 32'd4;
					wr = 1'b1;
					nxt = (a_op + immi) & ~32'd1;
					tk = 1'b1;
				end
			end
			rvx_pkg::OPC_BRANCH: begin
				case (f3)
					rvx_pkg::F3_BEQ:  cnd = a_op == b_op;
					rvx_pkg::F3_BNE:  cnd = a_op != b_op;
					rvx_pkg::F3_BLT:  cnd = $signed(a_op) < $signed(b_op);
					rvx_pkg::F3_BGE:  cnd = $signed(a_op) >= $signed(b_op);
					rvx_pkg::F3_BLTU: cnd = a_op < b_op;
					rvx_pkg::F3_BGEU: cnd = a_op >= b_op;
					default:          ok = 1'b0;
				endcase
				if (ok && cnd) begin
					nxt = pc_q + immb;
					tk = 1'b1;
				end
			end
			rvx_pkg::OPC_LOAD: begin
				if (f3 == 3'd3 || f3 > rvx_pkg::F3_LHU) begin
					ok = 1'b0;
				end else begin
					msize = 3'd1 << f3[1:0];
					kind = rvx_pkg::KIND_LOAD;
					wr = 1'b1;
				end
			end
			rvx_pkg::OPC_STORE: begin
				if (f3 > rvx_pkg::F3_LW) begin
					ok = 1'b0;
				end else begin
					msize = 3'd1 << f3[1:0];
					ea = a_op + imms;
					kind = rvx_pkg::KIND_STORE;
				end
			end
			rvx_pkg::OPC_SYSTEM: begin
				if (ir_q == rvx_pkg::ECALL_WORD) st = rvx_pkg::ST_ENV;
				else ok = 1'b0;
			end
			default: ok = 1'b0;
		endcase
		inr = ({1'b0, ea} + {30'd0, msize}) <= 33'(MEM_BYTES);
		if ((kind == rvx_pkg::KIND_LOAD || kind == rvx_pkg::KIND_STORE) && !inr)
			st = rvx_pkg::ST_RANGE;
		if (!ok) st = rvx_pkg::ST_ILL;
		if (halt_q) st = rvx_pkg::ST_HALT;
		if (st == rvx_pkg::ST_ILL || st == rvx_pkg::ST_RANGE || st == rvx_pkg::ST_HALT) begin
			wr = 1'b0;
			tk = 1'b0;
			nxt = pc_q;
			kind = rvx_pkg::KIND_ALU;
		end
	end

	// operand signedness of the high multiply forms
	assign mas = (f3 == rvx_pkg::F3_MULH || f3 == rvx_pkg::F3_MULHSU) && a_op[31];
	assign mbs = (f3 == rvx_pkg::F3_MULH) && b_op[31];
	assign prod = $signed({mas, a_op}) * $signed({mbs, b_op});

	rvx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (a_op),
		.divisor  (b_op),
		.sgn      (~f3[0]),
		.rem      (f3[1]),
		.done     (div_done),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			pc_q <= '0;
			halt_q <= 1'b0;
			clr_q <= '0;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cmd.wb) begin
				if (st_q == rvx_pkg::ST_HALT) halt_q <= 1'b1;
				else if (st_q == rvx_pkg::ST_OK || st_q == rvx_pkg::ST_ENV) pc_q <= nxt_q;
				if (wr_ok) rf_vld_q[rd] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ir_q <= in_word;
			ra_q <= rf[in_word[19:15]];
			rb_q <= rf[in_word[24:20]];
			va_q <= rf_vld_q[in_word[19:15]];
			vb_q <= rf_vld_q[in_word[24:20]];
		end
		if (cmd.wb && wr_ok) rf[rd] <= fval;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			st_q <= st;
			wr_q <= wr;
			tk_q <= tk;
			val_q <= val;
			nxt_q <= nxt;
			kind_q <= kind;
			ea_q <= ea;
			msize_q <= msize;
			mcnt_q <= '0;
			prod_s1 <= prod[63:0];
		end else if (cmd.mem_step) begin
			mcnt_q <= mcnt_q + 3'd1;
			if (mcnt_q != 3'd0) ld_q[8 * 2'(mcnt_q - 3'd1) +: 8] <= mrd_q;
		end
	end

	assign mwe = cmd.clr_step ||
		(cmd.mem_step && kind_q == rvx_pkg::KIND_STORE && mcnt_q < msize_q);
	assign maddr = cmd.clr_step ? clr_q : AW'(ea_q + {29'd0, mcnt_q});
	assign mwd = cmd.clr_step ? 8'd0 : b_op[8 * mcnt_q[1:0] +: 8];

	always_ff @(posedge clk) begin
		if (mwe) mem[maddr] <= mwd;
		mrd_q <= mem[maddr];
	end

	always_comb begin
		case (kind_q)
			rvx_pkg::KIND_MUL: fval = (f3 == rvx_pkg::F3_MUL) ? prod_s1[31:0] : prod_s1[63:32];
			rvx_pkg::KIND_DIV: fval = div_res;
			rvx_pkg::KIND_LOAD: begin
				case (f3)
					rvx_pkg::F3_LB: fval = {{24{ld_q[7]}}, ld_q[7:0]};
					rvx_pkg::F3_LH: fval = {{16{ld_q[15]}}, ld_q[15:0]};
					rvx_pkg::F3_LW: fval = ld_q;
					3'd4:           fval = {24'd0, ld_q[7:0]};
					default:        fval = {16'd0, ld_q[15:0]};
				endcase
			end
			default: fval = val_q;
		endcase
	end

	assign wr_ok = wr_q && (rd != 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			next_pc <= nxt_q;
			status_code <= st_q;
			reg_written <= wr_ok;
			dest_index <= wr_ok ? rd : 5'd0;
			dest_value <= wr_ok ? fval : 32'd0;
			branch_taken <= tk_q;
		end
	end

	assign sts.kind = kind;
	assign sts.mem_done = mcnt_q == msize_q;
	assign sts.div_done = div_done;
	assign sts.clr_done = clr_q == AW'(MEM_BYTES - 1);

endmodule

// ----- design/rvx_ctrl.sv -----
module rvx_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rvx_pkg::sts_t sts,
	output rvx_pkg::cmd_t cmd
);

	rvx_pkg::state_t state_q, state_d;
	logic out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rvx_pkg::S_CLEAR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.wb) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			rvx_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = rvx_pkg::S_IDLE;
			end
			rvx_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = rvx_pkg::S_EXEC;
				end
			end
			rvx_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.kind)
					rvx_pkg::KIND_LOAD, rvx_pkg::KIND_STORE: state_d = rvx_pkg::S_MEM;
					rvx_pkg::KIND_DIV: begin
						cmd.div_start = 1'b1;
						state_d = rvx_pkg::S_DIV;
					end
					default: state_d = rvx_pkg::S_WB;
				endcase
			end
			rvx_pkg::S_MEM: begin
				cmd.mem_step = 1'b1;
				if (sts.mem_done) state_d = rvx_pkg::S_WB;
			end
			rvx_pkg::S_DIV: begin
				if (sts.div_done) state_d = rvx_pkg::S_WB;
			end
			rvx_pkg::S_WB: begin
				// hold until the result register is free
				if (!out_vld_q || out_ready) begin
					cmd.wb = 1'b1;
					state_d = rvx_pkg::S_IDLE;
				end
			end
			default: state_d = rvx_pkg::S_IDLE;
		endcase
	end

	assign out_valid = out_vld_q;

endmodule
